/* hdl/fls_pkg.sv */
// ----------------------------------------------------------------------------
// fls_pkg: shared types and constants of the force-limited velocity scaler
// Pipeline depths, register indexes, reset values, regime codes and the
// sideband records that travel beside the square-root and divider pipelines.
// ----------------------------------------------------------------------------
package fls_pkg;

    localparam int LANES       = 3;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STEPS   = 33;
    localparam int DIV_LAT     = DIV_STEPS + 2;
    // input, squares, sums, compare, sqrt, regime, divisor, lanes
    localparam int IDX_D       = 3;
    localparam int IDX_E       = IDX_D + SQRT_STAGES + 1;
    localparam int IDX_F       = IDX_E + 1;
    localparam int PIPE_DEPTH  = IDX_F + DIV_LAT + 1;

    localparam int REG_W       = 31;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd2;

    localparam logic [REG_W-1:0] LOW_LIMIT_RST  = 31'd13107;
    localparam logic [REG_W-1:0] HIGH_LIMIT_RST = 31'd327680;
    localparam logic [REG_W-1:0] GAIN_RST       = 31'd327680;

    typedef enum logic [1:0] {
        REGIME_PASS    = 2'd0,
        REGIME_SCALED  = 2'd1,
        REGIME_CAPPED  = 2'd2,
        REGIME_BLOCKED = 2'd3
    } regime_t;

    typedef logic [62:0] divisor_t;

    typedef struct packed {
        logic [LANES-1:0][31:0] vel;
        logic                   dot_pos;
    } sq_side_t;

    typedef struct packed {
        logic [LANES-1:0][31:0] vel;
        regime_t                regime;
    } dv_side_t;

    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
    } lane_in_t;

endpackage

/* hdl/fls_if.sv */
// ----------------------------------------------------------------------------
// fls_sample_if / fls_command_if: valid-ready channels of the scaler
// One beat of sample_if carries velocity and force; one beat of command_if
// carries the commanded velocity and the regime code.
// ----------------------------------------------------------------------------
interface fls_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;

    modport source (output valid, vel_x, vel_y, vel_z, force_x, force_y, force_z,
                    input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, force_x, force_y, force_z,
                    output ready);
endinterface

interface fls_command_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cmd_x;
    logic signed [31:0] cmd_y;
    logic signed [31:0] cmd_z;
    logic [1:0]         regime;

    modport source (output valid, cmd_x, cmd_y, cmd_z, regime, input ready);
    modport sink   (input valid, cmd_x, cmd_y, cmd_z, regime, output ready);
endinterface

/* hdl/force_limited_velocity_scaler.sv */
// Throughput: one sample per cycle unless the output stalls; the 32-stage root
// pipeline and the 33-step divider lanes each retire one bit per stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the valid line and loads the limit and gain registers.
// ----------------------------------------------------------------------------
// force_limited_velocity_scaler: top level
// Squares and dot product, force magnitude root, regime choice, divisor, three
// divider lanes, and a merge that picks pass-through, quotient or zero.
// ----------------------------------------------------------------------------
module force_limited_velocity_scaler
(
    input  logic                           clk,
    input  logic                           rst_n,
    fls_sample_if.sink                     sample,
    fls_command_if.source                  command,
    input  logic                           cfg_we,
    input  logic [fls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fls_pkg::REG_W-1:0]      cfg_data
);
    import fls_pkg::*;

    logic [REG_W-1:0] low_reg, high_reg, gain_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic adv;

    logic [LANES-1:0][31:0] a_vel_reg, a_frc_reg;
    logic [LANES-1:0][63:0] b_sq_reg, b_pr_reg;
    logic [LANES-1:0]       b_neg_reg;
    logic [LANES-1:0][31:0] b_vel_reg;
    logic [63:0]            c_sum_reg, c_pos_reg, c_neg_reg;
    logic [LANES-1:0][31:0] c_vel_reg;
    logic [63:0]            d_sum_reg;
    sq_side_t               d_side_reg;
    sq_side_t               sq_line_reg [SQRT_STAGES];
    logic [31:0]            mag;
    dv_side_t               e_side_reg;
    logic [31:0]            e_sel_reg, e_mag_reg;
    dv_side_t               f_side_reg;
    divisor_t               f_div_reg;
    lane_in_t [LANES-1:0]   f_lane_reg;
    dv_side_t               dv_line_reg [DIV_LAT];
    logic signed [31:0]     lane_q [LANES];
    logic [LANES-1:0][31:0] out_cmd_reg;
    regime_t                out_regime_reg;
    logic                   out_valid_reg;
    regime_t                e_regime_next;
    logic [31:0]            e_sel_next;

    assign adv          = !out_valid_reg || command.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_LIMIT_RST;
            high_reg <= HIGH_LIMIT_RST;
            gain_reg <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW_LIMIT:  low_reg  <= cfg_data;
                CFG_HIGH_LIMIT: high_reg <= cfg_data;
                CFG_GAIN:       gain_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE_DEPTH-2:0], sample.valid};
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_comb
    begin
        if ({1'b0, low_reg} >= mag)
        begin
            e_regime_next = REGIME_PASS;
            e_sel_next    = mag;
        end
        else if ({1'b0, high_reg} >= mag)
        begin
            e_regime_next = REGIME_SCALED;
            e_sel_next    = mag;
        end
        else if (sq_line_reg[SQRT_STAGES-1].dot_pos)
        begin
            e_regime_next = REGIME_CAPPED;
            e_sel_next    = {1'b0, high_reg};
        end
        else
        begin
            e_regime_next = REGIME_BLOCKED;
            e_sel_next    = {1'b0, high_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [31:0] fa, va;
        if (adv)
        begin
            a_vel_reg <= {sample.vel_z, sample.vel_y, sample.vel_x};
            a_frc_reg <= {sample.force_z, sample.force_y, sample.force_x};

            for (int i = 0; i < LANES; i++)
            begin
                fa = a_frc_reg[i][31] ? 32'd0 - a_frc_reg[i] : a_frc_reg[i];
                va = a_vel_reg[i][31] ? 32'd0 - a_vel_reg[i] : a_vel_reg[i];
                b_sq_reg[i]  <= {32'd0, fa} * {32'd0, fa};
                b_pr_reg[i]  <= {32'd0, va} * {32'd0, fa};
                b_neg_reg[i] <= a_vel_reg[i][31] ^ a_frc_reg[i][31];
            end
            b_vel_reg <= a_vel_reg;

            c_sum_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_pos_reg <= (b_neg_reg[0] ? 64'd0 : b_pr_reg[0])
                       + (b_neg_reg[1] ? 64'd0 : b_pr_reg[1])
                       + (b_neg_reg[2] ? 64'd0 : b_pr_reg[2]);
            c_neg_reg <= (b_neg_reg[0] ? b_pr_reg[0] : 64'd0)
                       + (b_neg_reg[1] ? b_pr_reg[1] : 64'd0)
                       + (b_neg_reg[2] ? b_pr_reg[2] : 64'd0);
            c_vel_reg <= b_vel_reg;

            d_sum_reg          <= c_sum_reg;
            d_side_reg.vel     <= c_vel_reg;
            d_side_reg.dot_pos <= c_pos_reg > c_neg_reg;

            sq_line_reg[0] <= d_side_reg;
            for (int s = 1; s < SQRT_STAGES; s++)
                sq_line_reg[s] <= sq_line_reg[s-1];

            e_side_reg.vel    <= sq_line_reg[SQRT_STAGES-1].vel;
            e_side_reg.regime <= e_regime_next;
            e_sel_reg         <= e_sel_next;
            e_mag_reg         <= mag;

            f_side_reg <= e_side_reg;
            f_div_reg  <= {32'd0, gain_reg} * {31'd0, e_sel_reg};
            for (int i = 0; i < LANES; i++)
            begin
                f_lane_reg[i].neg <= e_side_reg.vel[i][31];
                f_lane_reg[i].mag <= e_side_reg.vel[i][31] ? 32'd0 - e_side_reg.vel[i]
                                                           : e_side_reg.vel[i];
            end

            dv_line_reg[0] <= f_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
                dv_line_reg[k] <= dv_line_reg[k-1];

            // merge lanes: pass raw velocity, divided value or zero
            out_regime_reg <= dv_line_reg[DIV_LAT-1].regime;
            for (int i = 0; i < LANES; i++)
            begin
                case (dv_line_reg[DIV_LAT-1].regime)
                    REGIME_PASS:    out_cmd_reg[i] <= dv_line_reg[DIV_LAT-1].vel[i];
                    REGIME_BLOCKED: out_cmd_reg[i] <= 32'd0;
                    default:        out_cmd_reg[i] <= lane_q[i];
                endcase
            end
        end
    end

    fls_sqrt u_sqrt
    (
        .clk      (clk),
        .en       (adv),
        .radicand (d_sum_reg),
        .root     (mag)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        fls_div_lane u_lane
        (
            .clk     (clk),
            .en      (adv),
            .lane_in (f_lane_reg[g]),
            .divisor (f_div_reg),
            .result  (lane_q[g])
        );
    end

    assign command.valid  = out_valid_reg;
    assign command.cmd_x  = out_cmd_reg[0];
    assign command.cmd_y  = out_cmd_reg[1];
    assign command.cmd_z  = out_cmd_reg[2];
    assign command.regime = out_regime_reg;

`ifndef SYNTHESIS
    a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid && command.regime == REGIME_BLOCKED |->
        command.cmd_x == 0 && command.cmd_y == 0 && command.cmd_z == 0)
        else $error("blocked command carries nonzero velocity");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> command.valid && !command.ready)
        else $error("input held off without a stalled output");

    a_scaled_above_low: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[IDX_E] && e_side_reg.regime == REGIME_SCALED |->
        e_mag_reg > {1'b0, low_reg} && e_sel_reg == e_mag_reg)
        else $error("scaled regime with magnitude at or below low limit");
`endif

endmodule

/* hdl/fls_sqrt.sv */
// ----------------------------------------------------------------------------
// fls_sqrt: pipelined integer square root
// One result bit per stage, floor of the root of a 64-bit radicand.
// ----------------------------------------------------------------------------
module fls_sqrt
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import fls_pkg::*;

    logic [63:0] x_reg [SQRT_STAGES];
    logic [63:0] r_reg [SQRT_STAGES];
    logic [63:0] x_src [SQRT_STAGES];
    logic [63:0] r_src [SQRT_STAGES];
    logic [63:0] x_next [SQRT_STAGES];
    logic [63:0] r_next [SQRT_STAGES];

    always_comb
    begin
        x_src[0] = radicand;
        r_src[0] = 64'd0;
        for (int s = 1; s < SQRT_STAGES; s++)
        begin
            x_src[s] = x_reg[s-1];
            r_src[s] = r_reg[s-1];
        end
    end

    always_comb
    begin
        logic [64:0] bitv;
        logic [64:0] trial;
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            bitv  = 65'd1 << (62 - 2 * s);
            trial = {1'b0, r_src[s]} + bitv;
            if ({1'b0, x_src[s]} >= trial)
            begin
                x_next[s] = x_src[s] - trial[63:0];
                r_next[s] = (r_src[s] >> 1) + bitv[63:0];
            end
            else
            begin
                x_next[s] = x_src[s];
                r_next[s] = r_src[s] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
            begin
                x_reg[s] <= x_next[s];
                r_reg[s] <= r_next[s];
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1][31:0];

endmodule

/* hdl/fls_div_lane.sv */
// ----------------------------------------------------------------------------
// fls_div_lane: one axis of the velocity divider
// Restoring division of |vel| * 2^32 by a 63-bit divisor, one quotient bit a
// stage, then sign and saturation to a signed Q16.16 word.
// ----------------------------------------------------------------------------
module fls_div_lane
(
    input  logic                 clk,
    input  logic                 en,
    input  fls_pkg::lane_in_t    lane_in,
    input  fls_pkg::divisor_t    divisor,
    output logic signed [31:0]   result
);
    import fls_pkg::*;

    logic [63:0]          rem_reg  [DIV_STEPS+1];
    logic [62:0]          d_reg    [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg    [DIV_STEPS+1];
    logic                 neg_reg  [DIV_STEPS+1];
    logic                 zero_reg [DIV_STEPS+1];
    logic                 ovf_reg  [DIV_STEPS+1];
    logic [63:0]          rem_next [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_next   [DIV_STEPS+1];
    logic signed [31:0]   res_reg;
    logic signed [31:0]   res_next;

    always_comb
    begin
        logic [95:0] shifted;
        rem_next[0] = {lane_in.mag, 32'd0};
        q_next[0]   = '0;
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            shifted = {33'd0, d_reg[j-1]} << (DIV_STEPS - j);
            if ({32'd0, rem_reg[j-1]} >= shifted)
            begin
                rem_next[j] = rem_reg[j-1] - shifted[63:0];
                q_next[j]   = {q_reg[j-1][DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = rem_reg[j-1];
                q_next[j]   = {q_reg[j-1][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    // saturate: overflow flag covers quotients past 33 bits and a zero divisor
    always_comb
    begin
        logic [DIV_STEPS-1:0] q;
        logic [31:0]          mag;
        q   = q_reg[DIV_STEPS];
        mag = q[31:0];
        if (zero_reg[DIV_STEPS])
            res_next = 32'sd0;
        else if (neg_reg[DIV_STEPS])
        begin
            if (ovf_reg[DIV_STEPS] || q > 33'h080000000)
                mag = 32'h80000000;
            res_next = $signed(32'd0 - mag);
        end
        else if (ovf_reg[DIV_STEPS] || q > 33'h07FFFFFFF)
            res_next = 32'sh7FFFFFFF;
        else
            res_next = $signed(q[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            d_reg[0]    <= divisor;
            neg_reg[0]  <= lane_in.neg;
            zero_reg[0] <= (lane_in.mag == 32'd0);
            ovf_reg[0]  <= ({32'd0, lane_in.mag} >= {divisor, 1'b0});
            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                d_reg[j]    <= d_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
            end
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule
